// ===== hw/rtl/bmts_pkg.sv =====
package bmts_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TOTAL_DOCS = 2'd0,
    REG_AVG_LEN    = 2'd1,
    REG_K1         = 2'd2,
    REG_B          = 2'd3
  } reg_idx_e;

  localparam int unsigned K1_W        = 16;
  localparam int unsigned B_W         = 13;
  localparam int unsigned SCORE_W     = 22;
  localparam int unsigned OUT_TDATA_W = 24;
  // The ratio (tf+1)(k1+1)/(...) never reaches 17.0, so Q5.16 holds it.
  localparam int unsigned RATIO_W     = 21;

  localparam logic [15:0]        LN2_Q16        = 16'd45426;
  localparam logic [B_W-1:0]     B_ONE          = 13'd4096;
  localparam logic [SCORE_W-1:0] SCORE_MAX      = 22'd4194303;
  localparam logic [31:0]        TOTAL_DOCS_RST = 32'd8400000;
  localparam logic [K1_W-1:0]    K1_RST         = 16'd6144;
  localparam logic [B_W-1:0]     B_RST          = 13'd3072;

  // Fraction table entry: floor(2^16 * log2(1 + idx/2^bits)), by repeated
  // squaring of a Q30 operand. Only called with constant arguments.
  function automatic logic [15:0] log_entry(int unsigned idx, int unsigned bits);
    logic [63:0] y;
    logic [15:0] r;
    y = (64'd1 << 30) + (64'(idx) << (30 - bits));
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y    = y >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bmts_fifo.sv =====
module bmts_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/bmts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage. The part of the
// dividend above the quotient bits must be below the divisor.
module bmts_div #(
  parameter int unsigned DVD_W  = 8,
  parameter int unsigned DSR_W  = 8,
  parameter int unsigned Q_W    = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [DVD_W-1:0]  dvd_i,
  input  logic [DSR_W-1:0]  dsr_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [Q_W];
  logic [DSR_W-1:0]  rem_q  [Q_W];
  logic [DVD_W-1:0]  dvd_q  [Q_W];
  logic [DSR_W-1:0]  dsr_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic              vld_in;
    logic [DSR_W-1:0]  rem_in;
    logic [DVD_W-1:0]  dvd_in;
    logic [DSR_W-1:0]  dsr_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [DSR_W:0]    trial, diff;
    logic              take;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = DSR_W'(dvd_i >> Q_W);
      assign dvd_in  = dvd_i;
      assign dsr_in  = dsr_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign dvd_in  = dvd_q[s-1];
      assign dsr_in  = dsr_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Bring in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_in, dvd_in[Q_W-1-s]};
    assign diff  = trial - {1'b0, dsr_in};
    assign take  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dvd_q[s]  <= dvd_in;
        dsr_q[s]  <= dsr_in;
        quo_q[s]  <= {quo_in[Q_W-2:0], take};
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign quo_o  = quo_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

// ===== hw/rtl/bmts_front.sv =====
// Front end: clamps df and computes idf = ln(2N+2) - ln(2df+1) in four stages.
module bmts_front #(
  parameter int unsigned COUNT_BITS     = 24,
  parameter int unsigned TF_BITS        = 16,
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COUNT_BITS-1:0] total_docs_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TF_BITS-1:0]    term_freq_i,
  input  logic [COUNT_BITS-1:0] doc_freq_i,
  input  logic [COUNT_BITS-1:0] doc_length_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  // Fields from bit 0: idf, term_freq, doc_length.
  output logic [$clog2(COUNT_BITS+2)+16+TF_BITS+COUNT_BITS-1:0] out_data_o
);

  localparam int unsigned XW       = COUNT_BITS + 2;
  localparam int unsigned PW       = $clog2(XW);
  localparam int unsigned LW       = PW + 16;
  localparam int unsigned TabDepth = 1 << LOG_TABLE_BITS;

  logic [15:0] log_tab [TabDepth];

  for (genvar g = 0; g < TabDepth; g++) begin : g_tab
    assign log_tab[g] = bmts_pkg::log_entry(g, LOG_TABLE_BITS);
  end

  function automatic logic [PW-1:0] lead_one(logic [XW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  logic adv;

  logic                  f1_vld_q, f2_vld_q, f3_vld_q, f4_vld_q;
  logic [XW-1:0]         f1_xhi_q, f1_xlo_q, f2_xhi_q, f2_xlo_q;
  logic [PW-1:0]         f2_phi_q, f2_plo_q;
  logic [LW-1:0]         f3_diff_q, f4_idf_q;
  logic [TF_BITS-1:0]    f1_tf_q, f2_tf_q, f3_tf_q, f4_tf_q;
  logic [COUNT_BITS-1:0] f1_len_q, f2_len_q, f3_len_q, f4_len_q;

  logic [COUNT_BITS-1:0]        df_c;
  logic [XW+LOG_TABLE_BITS-1:0] ext_hi, ext_lo;
  logic [LW-1:0]                log_hi, log_lo;
  logic [LW+15:0]               idf_prod;

  assign adv         = !f4_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = f4_vld_q;
  assign out_data_o  = {f4_len_q, f4_tf_q, f4_idf_q};

  // Stage one: clamp df to N and form the two log arguments.
  assign df_c = (doc_freq_i > total_docs_i) ? total_docs_i : doc_freq_i;

  // Stage three: fraction bits below the leading one index the table.
  assign ext_hi = {f2_xhi_q, {LOG_TABLE_BITS{1'b0}}} >> f2_phi_q;
  assign ext_lo = {f2_xlo_q, {LOG_TABLE_BITS{1'b0}}} >> f2_plo_q;
  assign log_hi = {f2_phi_q, log_tab[ext_hi[LOG_TABLE_BITS-1:0]]};
  assign log_lo = {f2_plo_q, log_tab[ext_lo[LOG_TABLE_BITS-1:0]]};

  // Stage four: scale the base-two difference by ln 2.
  assign idf_prod = (LW+16)'(f3_diff_q) * (LW+16)'(bmts_pkg::LN2_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      f4_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_xhi_q  <= (XW'(total_docs_i) << 1) + XW'(2);
      f1_xlo_q  <= (XW'(df_c) << 1) + XW'(1);
      f1_tf_q   <= term_freq_i;
      f1_len_q  <= doc_length_i;
      f2_phi_q  <= lead_one(f1_xhi_q);
      f2_plo_q  <= lead_one(f1_xlo_q);
      f2_xhi_q  <= f1_xhi_q;
      f2_xlo_q  <= f1_xlo_q;
      f2_tf_q   <= f1_tf_q;
      f2_len_q  <= f1_len_q;
      f3_diff_q <= log_hi - log_lo;
      f3_tf_q   <= f2_tf_q;
      f3_len_q  <= f2_len_q;
      f4_idf_q  <= idf_prod[LW+15:16];
      f4_tf_q   <= f3_tf_q;
      f4_len_q  <= f3_len_q;
    end
  end

endmodule

// ===== hw/rtl/bmts_back.sv =====
// Back end: length normalization, the tf ratio and the final score.
module bmts_back #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned TF_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [COUNT_BITS-1:0]             avg_len_i,
  input  logic [bmts_pkg::K1_W-1:0]         k1_i,
  input  logic [bmts_pkg::B_W-1:0]          b_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  // Fields from bit 0: idf, term_freq, doc_length.
  input  logic [$clog2(COUNT_BITS+2)+16+TF_BITS+COUNT_BITS-1:0] in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bmts_pkg::SCORE_W-1:0]      score_o,
  output logic                              saturated_o
);

  localparam int unsigned IdfW   = $clog2(COUNT_BITS + 2) + 16;
  localparam int unsigned TW     = TF_BITS + 1;
  localparam int unsigned NumW   = TW + 17;
  localparam int unsigned BlW    = COUNT_BITS + bmts_pkg::B_W;
  localparam int unsigned NormW  = BlW + 1;
  localparam int unsigned LoW    = NormW / 2;
  localparam int unsigned HiW    = NormW - LoW;
  localparam int unsigned KFullW = NormW + bmts_pkg::K1_W;
  localparam int unsigned KnW    = KFullW - 12;
  localparam int unsigned DenW   = ((TW + 12 > KnW) ? TW + 12 : KnW) + 1;
  localparam int unsigned DvbW   = NumW + 16;
  localparam int unsigned SideW  = IdfW + TW + NumW;
  localparam int unsigned ProdW  = IdfW + bmts_pkg::RATIO_W;

  logic adv;
  logic out_vld_q;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_vld_q;

  // Register operands. Only the user keeps them fixed with items in flight.
  logic [COUNT_BITS-1:0]    avg_fix;
  logic [bmts_pkg::B_W-1:0] b_c;

  assign avg_fix = (avg_len_i == '0) ? COUNT_BITS'(1) : avg_len_i;
  assign b_c     = (b_i > bmts_pkg::B_ONE) ? bmts_pkg::B_ONE : b_i;

  // Stage zero: tf+1, the numerator and b*len.
  logic [IdfW-1:0]       in_idf;
  logic [TF_BITS-1:0]    in_tf;
  logic [COUNT_BITS-1:0] in_len;
  logic [TW-1:0]         in_t;

  assign in_idf = in_data_i[IdfW-1:0];
  assign in_tf  = in_data_i[IdfW+TF_BITS-1:IdfW];
  assign in_len = in_data_i[IdfW+TF_BITS+COUNT_BITS-1:IdfW+TF_BITS];
  assign in_t   = TW'(in_tf) + TW'(1);

  logic                  s0_vld_q;
  logic [BlW-1:0]        s0_bl_q;
  logic [COUNT_BITS-1:0] s0_avg_q;
  logic [SideW-1:0]      s0_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_bl_q   <= BlW'(b_c) * BlW'(in_len);
      s0_avg_q  <= avg_fix;
      s0_side_q <= {in_idf, in_t, NumW'(in_t) * (NumW'(k1_i) + NumW'(bmts_pkg::B_ONE))};
    end
  end

  // Quotient of b*len by the average length.
  logic             a_vld;
  logic [BlW-1:0]   a_quo;
  logic [SideW-1:0] a_side;

  bmts_div #(
    .DVD_W (BlW),
    .DSR_W (COUNT_BITS),
    .Q_W   (BlW),
    .SIDE_W(SideW)
  ) u_len_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (s0_vld_q),
    .dvd_i (s0_bl_q),
    .dsr_i (s0_avg_q),
    .side_i(s0_side_q),
    .vld_o (a_vld),
    .quo_o (a_quo),
    .side_o(a_side)
  );

  // Stages one to four: norm, k1*norm in two partial products, denominator.
  logic                        s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [NormW-1:0]            s1_norm_q;
  logic [LoW+bmts_pkg::K1_W-1:0] s2_pplo_q;
  logic [HiW+bmts_pkg::K1_W-1:0] s2_pphi_q;
  logic [KnW-1:0]              s3_kn_q;
  logic [SideW-1:0]            s1_side_q, s2_side_q, s3_side_q;
  logic [DenW-1:0]             s4_den_q;
  logic [DvbW-1:0]             s4_dvd_q;
  logic [IdfW-1:0]             s4_idf_q;
  logic [KFullW-1:0]           k_full;
  logic [TW-1:0]               s3_t;
  logic [NumW-1:0]             s3_num;

  assign k_full = KFullW'(s2_pplo_q) + (KFullW'(s2_pphi_q) << LoW);
  assign s3_num = s3_side_q[NumW-1:0];
  assign s3_t   = s3_side_q[NumW+TW-1:NumW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_norm_q <= NormW'(bmts_pkg::B_ONE - b_c) + NormW'(a_quo);
      s1_side_q <= a_side;
      s2_pplo_q <= (LoW+bmts_pkg::K1_W)'(k1_i) * (LoW+bmts_pkg::K1_W)'(s1_norm_q[LoW-1:0]);
      s2_pphi_q <= (HiW+bmts_pkg::K1_W)'(k1_i) *
                   (HiW+bmts_pkg::K1_W)'(s1_norm_q[NormW-1:LoW]);
      s2_side_q <= s1_side_q;
      s3_kn_q   <= k_full[KFullW-1:12];
      s3_side_q <= s2_side_q;
      s4_den_q  <= (DenW'(s3_t) << 12) + DenW'(s3_kn_q);
      s4_dvd_q  <= {s3_num, 16'd0};
      s4_idf_q  <= s3_side_q[SideW-1:NumW+TW];
    end
  end

  // Ratio num*2^16/den, 21 quotient bits.
  logic                          r_vld;
  logic [bmts_pkg::RATIO_W-1:0]  r_quo;
  logic [IdfW-1:0]               r_idf;

  bmts_div #(
    .DVD_W (DvbW),
    .DSR_W (DenW),
    .Q_W   (bmts_pkg::RATIO_W),
    .SIDE_W(IdfW)
  ) u_ratio_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (s4_vld_q),
    .dvd_i (s4_dvd_q),
    .dsr_i (s4_den_q),
    .side_i(s4_idf_q),
    .vld_o (r_vld),
    .quo_o (r_quo),
    .side_o(r_idf)
  );

  // Stage five: idf times ratio; then saturate into the output register.
  logic                        s5_vld_q;
  logic [ProdW-1:0]            s5_prod_q;
  logic [ProdW-17:0]           score_full;
  logic                        sat_c;
  logic [bmts_pkg::SCORE_W-1:0] score_q;
  logic                        sat_q;

  assign score_full = s5_prod_q[ProdW-1:16];
  assign sat_c      = (score_full > (ProdW-16)'(bmts_pkg::SCORE_MAX));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_prod_q <= ProdW'(r_idf) * ProdW'(r_quo);
      score_q   <= sat_c ? bmts_pkg::SCORE_MAX : score_full[bmts_pkg::SCORE_W-1:0];
      sat_q     <= sat_c;
    end
  end

  assign score_o     = score_q;
  assign saturated_o = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= a_vld;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= r_vld;
      out_vld_q <= s5_vld_q;
    end
  end

endmodule

// ===== hw/rtl/bm25_term_score_unit.sv =====
// BM25 term score unit. Takes one posting (term frequency, document frequency,
// document length) per beat and returns one unsigned Q6.16 score per beat, with
// a flag when the score was clamped. It sustains one posting per clock cycle
// while the output is not stalled. Postings pass the idf front end, a two-entry
// queue, and the back end with its two bit-per-stage dividers (length over
// average length, then the tf ratio) and the multiply stages. A stall on the
// output holds the back end; the queue lets the front end keep taking beats
// until it is full. Registers: 0 total documents, 1 average length, 2 k1
// (Q4.12), 3 b (Q1.12); write them only while no posting is in flight.
module bm25_term_score_unit #(
  parameter int unsigned COUNT_BITS     = 24,
  parameter int unsigned TF_BITS        = 16,
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  bmts_pkg::reg_idx_e                   cfg_idx_i,
  input  logic [COUNT_BITS-1:0]                cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // term_freq, doc_freq, doc_length (from bit 0), zero padded to bytes
  input  logic [((TF_BITS+2*COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // score, zero padded to bytes
  output logic [bmts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // saturated
  output logic                                 m_axis_tuser
);

  localparam int unsigned IdfW  = $clog2(COUNT_BITS + 2) + 16;
  localparam int unsigned ItemW = IdfW + TF_BITS + COUNT_BITS;

  // Configuration registers.
  logic [COUNT_BITS-1:0]     total_docs_q, avg_len_q;
  logic [bmts_pkg::K1_W-1:0] k1_q;
  logic [bmts_pkg::B_W-1:0]  b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_docs_q <= COUNT_BITS'(bmts_pkg::TOTAL_DOCS_RST);
      avg_len_q    <= COUNT_BITS'(1);
      k1_q         <= bmts_pkg::K1_RST;
      b_q          <= bmts_pkg::B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmts_pkg::REG_TOTAL_DOCS: total_docs_q <= cfg_data_i;
        bmts_pkg::REG_AVG_LEN:    avg_len_q    <= cfg_data_i;
        bmts_pkg::REG_K1:         k1_q         <= cfg_data_i[bmts_pkg::K1_W-1:0];
        bmts_pkg::REG_B:          b_q          <= cfg_data_i[bmts_pkg::B_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: idf per posting.
  logic             fr_valid, fr_ready;
  logic [ItemW-1:0] fr_data;

  bmts_front #(
    .COUNT_BITS    (COUNT_BITS),
    .TF_BITS       (TF_BITS),
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .total_docs_i(total_docs_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .term_freq_i (s_axis_tdata[TF_BITS-1:0]),
    .doc_freq_i  (s_axis_tdata[TF_BITS+COUNT_BITS-1:TF_BITS]),
    .doc_length_i(s_axis_tdata[TF_BITS+2*COUNT_BITS-1:TF_BITS+COUNT_BITS]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  // Queue between the two halves.
  logic             bk_valid, bk_ready;
  logic [ItemW-1:0] bk_data;

  bmts_fifo #(
    .WIDTH(ItemW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (fr_data),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_data)
  );

  // Back end: ratio and score.
  logic [bmts_pkg::SCORE_W-1:0] score;

  bmts_back #(
    .COUNT_BITS(COUNT_BITS),
    .TF_BITS   (TF_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avg_len_i  (avg_len_q),
    .k1_i       (k1_q),
    .b_i        (b_q),
    .in_valid_i (bk_valid),
    .in_ready_o (bk_ready),
    .in_data_i  (bk_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .score_o    (score),
    .saturated_o(m_axis_tuser)
  );

  assign m_axis_tdata = bmts_pkg::OUT_TDATA_W'(score);

endmodule

// ===== hw/rtl/bmts_checker.sv =====
module bmts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Postings taken but not yet delivered.
  logic [7:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 8'd0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // A result beat never appears without a posting behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 8'd0)
    else $error("result beat without outstanding posting");

  // A clamped score is the maximum.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:0] == bmts_pkg::SCORE_MAX)
    else $error("saturated flag with score below maximum");

  // Padding bits of the result stay clear.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'd0)
    else $error("nonzero padding in result beat");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind bm25_term_score_unit bmts_checker u_bmts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== dv/tb_bm25_term_score_unit.sv =====
module tb_bm25_term_score_unit;

  localparam int unsigned CNT_W = 24;
  localparam int unsigned TFW = 16;
  localparam int unsigned LTB = 8;
  localparam int unsigned LATENCY = CNT_W + 46;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CNT_W-1:0] doc_length;
    logic [CNT_W-1:0] doc_freq;
    logic [TFW-1:0]   term_freq;
  } posting_t;

  typedef struct packed {
    logic [bmts_pkg::SCORE_W-1:0] score;
    logic                         saturated;
  } score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  bmts_pkg::reg_idx_e cfg_idx_i = bmts_pkg::REG_TOTAL_DOCS;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [bmts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  bm25_term_score_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration registers.
  logic [63:0] n_docs, avg_len, k1, b_w;
  logic [15:0] frac_lut [0:(1<<LTB)-1];

  posting_t pending_q[$];
  score_t   expected_q[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  logic hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;
  int errors = 0, n_scored = 0, n_sat = 0;
  longint unsigned cycles = 0;

  // Fraction table: floor(2^16*log2(1+i/256)) by squaring a Q30 value.
  function automatic logic [15:0] frac_log(int unsigned idx);
    logic [63:0] y;
    logic [15:0] r;
    y = (64'd1 << 30) + (64'(idx) << (30 - LTB));
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int p;
    logic [63:0] idx;
    p = 0;
    for (int i = 63; i >= 0; i--)
      if (x[i] && p == 0) p = i;
    if (p >= LTB) idx = (x >> (p - LTB)) & 64'hFF;
    else idx = (x << (LTB - p)) & 64'hFF;
    return (64'(p) << 16) + frac_lut[idx];
  endfunction

  function automatic score_t bm25_score(posting_t ps);
    logic [63:0] tf, df, len, avg, bb, idf, t, norm, kn, num, den, q, rem, sc;
    score_t r;
    tf = ps.term_freq;
    df = ps.doc_freq;
    len = ps.doc_length;
    avg = (avg_len == 0) ? 64'd1 : avg_len;
    bb = (b_w > 4096) ? 64'd4096 : b_w;
    if (df > n_docs) df = n_docs;
    idf = ((log2_fix(2 * n_docs + 2) - log2_fix(2 * df + 1)) * 45426) >> 16;
    t = tf + 1;
    norm = (4096 - bb) + (bb * len) / avg;
    kn = (k1 * norm) >> 12;
    num = t * (k1 + 4096);
    den = (t << 12) + kn;
    q = num / den;
    rem = num % den;
    for (int k = 0; k < 16; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    sc = (idf * q) >> 16;
    if (sc > 64'(bmts_pkg::SCORE_MAX)) begin
      r.score = bmts_pkg::SCORE_MAX;
      r.saturated = 1'b1;
    end else begin
      r.score = sc[bmts_pkg::SCORE_W-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  // Driver: presents postings from the pending queue and predicts on acceptance.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_q.insert(expected_q.size(), bm25_score(posting_t'(s_axis_tdata)));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 64'(pending_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver hold: once requested, counts a long stretch with tready low.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Monitor: checks each score beat against the oldest prediction.
  always @(posedge clk_i) begin
    score_t exp_s;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("score beat with nothing expected: score %0d",
               m_axis_tdata[bmts_pkg::SCORE_W-1:0]);
        errors++;
      end else begin
        exp_s = expected_q.pop_front();
        n_scored++;
        if (exp_s.saturated) n_sat++;
        if (m_axis_tdata[bmts_pkg::SCORE_W-1:0] !== exp_s.score) begin
          $error("score: expected %0d, got %0d", exp_s.score,
                 m_axis_tdata[bmts_pkg::SCORE_W-1:0]);
          errors++;
        end
        if (m_axis_tuser !== exp_s.saturated) begin
          $error("saturated: expected %0d, got %0d", exp_s.saturated, m_axis_tuser);
          errors++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bm25_term_score_unit");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(bmts_pkg::reg_idx_e idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bmts_pkg::REG_TOTAL_DOCS: n_docs = val & 64'hFFFFFF;
      bmts_pkg::REG_AVG_LEN:    avg_len = val & 64'hFFFFFF;
      bmts_pkg::REG_K1:         k1 = val & 64'hFFFF;
      bmts_pkg::REG_B:          b_w = val & 64'h1FFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic add(logic [63:0] tf, logic [63:0] df, logic [63:0] len);
    posting_t ps;
    ps.term_freq = tf[TFW-1:0];
    ps.doc_freq = df[CNT_W-1:0];
    ps.doc_length = len[CNT_W-1:0];
    pending_q.insert(pending_q.size(), ps);
  endtask

  // Mostly realistic postings, some with full-range random fields.
  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        add($urandom, $urandom, $urandom);
      else
        add($urandom_range(20), $urandom_range(n_docs), $urandom_range(3 * avg_len + 4));
    end
  endtask

  initial begin
    for (int i = 0; i < (1 << LTB); i++) frac_lut[i] = frac_log(i);
    n_docs = 8400000;
    avg_len = 1;
    k1 = 6144;
    b_w = 3072;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed postings at the reset settings.
    add(0, 0, 0);
    add(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add(0, 24'hFFFFFF, 0);
    add(16'hFFFF, 0, 0);
    add(1, 1, 1);
    add(5, 8400000, 100);
    add(5, 8400001, 100);
    add(3, 2, 24'hFFFFFF);
    add(65535, 0, 1);
    wait_drained();

    // Extremes: N, k1 max, b over one, avg zero; then N, k1, b zero, avg max.
    write_reg(bmts_pkg::REG_TOTAL_DOCS, 24'hFFFFFF);
    write_reg(bmts_pkg::REG_AVG_LEN, 0);
    write_reg(bmts_pkg::REG_K1, 16'hFFFF);
    write_reg(bmts_pkg::REG_B, 13'h1FFF);
    add(0, 0, 0);
    add(16'hFFFF, 0, 24'hFFFFFF);
    add(7, 24'hFFFFFF, 3);
    add(0, 1, 1);
    wait_drained();
    write_reg(bmts_pkg::REG_TOTAL_DOCS, 0);
    write_reg(bmts_pkg::REG_AVG_LEN, 24'hFFFFFF);
    write_reg(bmts_pkg::REG_K1, 0);
    write_reg(bmts_pkg::REG_B, 0);
    add(0, 0, 0);
    add(100, 24'hFFFFFF, 24'hFFFFFF);
    add(16'hFFFF, 5, 7);
    wait_drained();

    // Random phases under changing settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(bmts_pkg::REG_TOTAL_DOCS, (ph == 0) ? 1 : $urandom_range(1, 24'hFFFFFF));
      write_reg(bmts_pkg::REG_AVG_LEN, (ph == 1) ? 24'hFFFFFF : $urandom_range(1, 500));
      write_reg(bmts_pkg::REG_K1, (ph == 2) ? 0 : $urandom_range(16'hFFFF));
      write_reg(bmts_pkg::REG_B, (ph == 3) ? 4096 : $urandom_range(13'h1FFF));
      send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 86 : 0;
      recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 34 : 0;
      if (ph == 4) hold_req = 1'b1;
      add_random(180);
      wait_drained();
    end

    $display("Checked %0d scores (%0d clamped): directed corner postings, extreme settings,",
             n_scored, n_sat);
    $display("and six random phases with both idle mixes and a long output stall.");
    if (errors == 0)
      $display("PASS bm25_term_score_unit");
    else
      $display("FAIL bm25_term_score_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bmts_pkg.sv
hw/rtl/bmts_fifo.sv
hw/rtl/bmts_div.sv
hw/rtl/bmts_front.sv
hw/rtl/bmts_back.sv
hw/rtl/bm25_term_score_unit.sv
hw/rtl/bmts_checker.sv
dv/tb_bm25_term_score_unit.sv
